// File: sv/phr_pkg.sv
// phr_pkg: shared types and constants for the packet header receiver
// record passed from the front to the back, result item, event and status codes
// no dependencies

package phr_pkg;

	localparam logic [7:0] FLAG_MASK  = 8'b10000001;
	localparam logic [7:0] FLAG_SYNC  = 8'b10000000;
	localparam logic [7:0] FLAG_CLOSE = 8'b00000001;
	localparam logic [15:0] WORD_ONES = 16'hffff;

	localparam int COUNT_W = 19;

	// header byte positions
	localparam logic [COUNT_W-1:0] POS_LEN_HI  = 19'd0;
	localparam logic [COUNT_W-1:0] POS_LEN_LO  = 19'd1;
	localparam logic [COUNT_W-1:0] POS_CSUM_HI = 19'd2;
	localparam logic [COUNT_W-1:0] POS_CSUM_LO = 19'd3;
	localparam logic [COUNT_W-1:0] POS_SEQ_0   = 19'd4;
	localparam logic [COUNT_W-1:0] POS_SEQ_1   = 19'd5;
	localparam logic [COUNT_W-1:0] POS_SEQ_2   = 19'd6;
	localparam logic [COUNT_W-1:0] POS_SEQ_3   = 19'd7;
	localparam logic [COUNT_W-1:0] POS_FLAG    = 19'd8;
	localparam logic [COUNT_W-1:0] POS_SRC_HI  = 19'd12;
	localparam logic [COUNT_W-1:0] POS_SRC_LO  = 19'd13;
	localparam logic [COUNT_W-1:0] POS_HDR_END = 19'd15;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		CS_NONE     = 2'd0,
		CS_MATCH    = 2'd1,
		CS_MISMATCH = 2'd2
	} csum_status_t;

	typedef enum logic [2:0] {
		EV_NONE       = 3'd0,
		EV_STORED     = 3'd1,
		EV_DUP_SYNC   = 3'd2,
		EV_TABLE_FULL = 3'd3,
		EV_CLOSED     = 3'd4,
		EV_CLOSE_MISS = 3'd5
	} table_event_t;

	// one classified byte on its way from front to back
	typedef struct packed {
		logic         payload_valid;
		logic [7:0]   payload_byte;
		logic         header_done;
		logic [15:0]  source_addr;
		logic [31:0]  seq;
		logic [7:0]   flag;
		logic         flag_forbidden;
		csum_status_t checksum_status;
		logic         length_bad;
	} rec_t;

	typedef struct packed {
		logic         payload_valid;
		logic [7:0]   payload_byte;
		logic         header_done;
		logic [15:0]  source_addr;
		logic         flag_forbidden;
		logic         seq_error;
		table_event_t table_event;
		logic [2:0]   table_port;
		csum_status_t checksum_status;
		logic         length_bad;
	} res_t;

endpackage

// File: sv/phr_fifo.sv
// phr_fifo: small register queue with simultaneous write and read
// generic width and depth, no package use

module phr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == (AW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH-1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH-1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + (AW+1)'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - (AW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// File: sv/phr_front.sv
// phr_front: byte counter, header field capture, word sum and checksum/length checks
// depends on phr_pkg

module phr_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    data_byte,
	input  logic          last_byte,
	output phr_pkg::rec_t rec
);

	localparam int CW = phr_pkg::COUNT_W;

	logic [CW-1:0] count_q;
	logic [15:0]   len_q;
	logic [15:0]   csum_q;
	logic [31:0]   seq_q;
	logic [7:0]    flag_q;
	logic [15:0]   src_q;
	logic [7:0]    pend_q;
	logic [31:0]   sum_q;

	logic [CW-1:0] count_next;
	logic [15:0]   len_next;
	logic [15:0]   csum_next;
	logic [31:0]   seq_next;
	logic [7:0]    flag_next;
	logic [15:0]   src_next;
	logic [7:0]    pend_next;
	logic [31:0]   sum_next;
	logic [31:0]   sum_base;
	logic [16:0]   folded;
	logic [15:0]   sum_inv;
	logic [CW-1:0] check_pos;
	logic          do_check;
	logic          forbidden;
	logic          hdr_end;

	always_comb begin
		len_next  = len_q;
		csum_next = csum_q;
		seq_next  = seq_q;
		flag_next = flag_q;
		src_next  = src_q;
		forbidden = 1'b0;
		hdr_end   = 1'b0;
		case (count_q)
			phr_pkg::POS_LEN_HI:  len_next  = {data_byte, 8'h00};
			phr_pkg::POS_LEN_LO:  len_next  = len_q | {8'h00, data_byte};
			phr_pkg::POS_CSUM_HI: csum_next = {data_byte, 8'h00};
			phr_pkg::POS_CSUM_LO: csum_next = csum_q | {8'h00, data_byte};
			phr_pkg::POS_SEQ_0:   seq_next  = {16'h0000, data_byte, 8'h00};
			phr_pkg::POS_SEQ_1,
			phr_pkg::POS_SEQ_2:   seq_next  = (seq_q | {24'h000000, data_byte}) << 8;
			phr_pkg::POS_SEQ_3:   seq_next  = seq_q | {24'h000000, data_byte};
			phr_pkg::POS_FLAG: begin
				flag_next = data_byte;
				forbidden = ((data_byte & phr_pkg::FLAG_MASK) == phr_pkg::FLAG_MASK);
			end
			phr_pkg::POS_SRC_HI:  src_next  = {data_byte, 8'h00};
			phr_pkg::POS_SRC_LO:  src_next  = src_q | {8'h00, data_byte};
			phr_pkg::POS_HDR_END: hdr_end   = 1'b1;
			default: ;
		endcase
	end

	// word sum restarts at byte zero, checksum word is skipped
	always_comb begin
		sum_base  = (count_q == phr_pkg::POS_LEN_HI) ? 32'h0 : sum_q;
		sum_next  = sum_base;
		pend_next = pend_q;
		if (!count_q[0]) begin
			if (count_q != phr_pkg::POS_CSUM_HI) begin
				pend_next = data_byte;
			end
		end else if (count_q != phr_pkg::POS_CSUM_LO) begin
			sum_next  = sum_base + {16'h0000, pend_q, data_byte};
			pend_next = 8'h00;
		end
		check_pos = {1'b0, len_next, 2'b00} - CW'(1);
		do_check  = (len_next >= 16'd4) && (count_q == check_pos);
		if (sum_next[31:16] != 16'h0000) begin
			folded = {1'b0, sum_next[15:0]} + {1'b0, sum_next[31:16]};
		end else begin
			folded = {1'b0, sum_next[15:0]};
		end
		sum_inv = phr_pkg::WORD_ONES & ~folded[15:0];
		if (do_check) begin
			sum_next = {16'h0000, sum_inv};
		end
	end

	assign count_next = last_byte ? '0 : count_q + CW'(1);

	always_comb begin
		rec.payload_valid   = (count_q > phr_pkg::POS_HDR_END);
		rec.payload_byte    = rec.payload_valid ? data_byte : 8'h00;
		rec.header_done     = hdr_end;
		rec.source_addr     = hdr_end ? src_q : 16'h0000;
		rec.seq             = seq_q;
		rec.flag            = flag_q;
		rec.flag_forbidden  = forbidden;
		if (!do_check) begin
			rec.checksum_status = phr_pkg::CS_NONE;
		end else if (csum_next == sum_inv) begin
			rec.checksum_status = phr_pkg::CS_MATCH;
		end else begin
			rec.checksum_status = phr_pkg::CS_MISMATCH;
		end
		rec.length_bad = last_byte &&
			(({1'b0, count_q} + (CW+1)'(1)) != {2'b00, len_next, 2'b00});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			len_q   <= '0;
			csum_q  <= '0;
			seq_q   <= '0;
			flag_q  <= '0;
			src_q   <= '0;
			pend_q  <= '0;
			sum_q   <= '0;
		end else if (accept) begin
			count_q <= count_next;
			len_q   <= len_next;
			csum_q  <= csum_next;
			seq_q   <= seq_next;
			flag_q  <= flag_next;
			src_q   <= src_next;
			pend_q  <= pend_next;
			sum_q   <= sum_next;
		end
	end

endmodule

// File: sv/phr_back.sv
// phr_back: port table lookup, sequence check, sync and close handling
// depends on phr_pkg; takes records from the front queue, fills the result queue

module phr_back #(
	parameter int NUM_PORTS = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rec_valid,
	input  phr_pkg::rec_t rec,
	output logic          rec_take,
	input  logic          res_ready,
	output phr_pkg::res_t res
);

	localparam int IW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
	localparam int TW = (IW > 3) ? IW : 3;

	logic [NUM_PORTS-1:0] used_q;
	logic [15:0]          addr_q [NUM_PORTS];
	logic [31:0]          pseq_q [NUM_PORTS];

	logic [NUM_PORTS-1:0] hit;
	logic [NUM_PORTS-1:0] seq_ok;
	logic [NUM_PORTS-1:0] first_hit;
	logic [NUM_PORTS-1:0] first_free;
	logic [IW-1:0]        hit_idx;
	logic [IW-1:0]        free_idx;
	logic [TW-1:0]        port_ext;
	logic                 any_hit;
	logic                 any_free;
	logic                 is_sync;
	logic                 is_close;
	logic                 do_table;

	assign rec_take = rec_valid && res_ready;
	assign do_table = rec_take && rec.header_done;
	assign is_sync  = ((rec.flag & phr_pkg::FLAG_MASK) == phr_pkg::FLAG_SYNC);
	assign is_close = ((rec.flag & phr_pkg::FLAG_MASK) == phr_pkg::FLAG_CLOSE);

	// every entry compares in parallel; lowest set bit wins
	always_comb begin
		for (int i = 0; i < NUM_PORTS; i++) begin
			hit[i]    = used_q[i] && (addr_q[i] == rec.source_addr);
			seq_ok[i] = (rec.seq == pseq_q[i] + 32'd1);
		end
		first_hit  = hit & (~hit + NUM_PORTS'(1));
		first_free = ~used_q & (used_q + NUM_PORTS'(1));
		any_hit    = |hit;
		any_free   = ~&used_q;
		hit_idx    = '0;
		free_idx   = '0;
		for (int i = 0; i < NUM_PORTS; i++) begin
			if (first_hit[i]) begin
				hit_idx = hit_idx | IW'(i);
			end
			if (first_free[i]) begin
				free_idx = free_idx | IW'(i);
			end
		end
	end

	always_comb begin
		res.payload_valid   = rec.payload_valid;
		res.payload_byte    = rec.payload_byte;
		res.header_done     = rec.header_done;
		res.source_addr     = rec.source_addr;
		res.flag_forbidden  = rec.flag_forbidden;
		res.checksum_status = rec.checksum_status;
		res.length_bad      = rec.length_bad;
		res.seq_error       = rec.header_done && (|(first_hit & ~seq_ok));
		res.table_event     = phr_pkg::EV_NONE;
		port_ext            = '0;
		if (rec.header_done) begin
			if (is_sync) begin
				if (any_hit) begin
					res.table_event = phr_pkg::EV_DUP_SYNC;
				end else if (any_free) begin
					res.table_event = phr_pkg::EV_STORED;
					port_ext        = TW'(free_idx);
				end else begin
					res.table_event = phr_pkg::EV_TABLE_FULL;
				end
			end else if (is_close) begin
				if (any_hit) begin
					res.table_event = phr_pkg::EV_CLOSED;
					port_ext        = TW'(hit_idx);
				end else begin
					res.table_event = phr_pkg::EV_CLOSE_MISS;
				end
			end
		end
		res.table_port = port_ext[2:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (do_table) begin
			for (int i = 0; i < NUM_PORTS; i++) begin
				if (is_sync && !any_hit && first_free[i]) begin
					used_q[i] <= 1'b1;
				end else if (is_close && first_hit[i]) begin
					used_q[i] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_table) begin
			for (int i = 0; i < NUM_PORTS; i++) begin
				if (first_hit[i] && seq_ok[i]) begin
					pseq_q[i] <= pseq_q[i] + 32'd1;
				end else if (is_sync && !any_hit && first_free[i]) begin
					addr_q[i] <= rec.source_addr;
					pseq_q[i] <= rec.seq;
				end
			end
		end
	end

endmodule

// File: sv/packet_header_receiver.sv
// packet_header_receiver: top level, front classifier, record queue, table back end, result queue
// depends on phr_pkg, phr_fifo, phr_front, phr_back

// Takes one packet byte per transfer and gives one result per byte, in order. The
// sustained rate is one byte per cycle while full is low: the front handles a byte in the
// cycle of its transfer and writes a record into a two-entry queue, the back end looks up
// the port table (all entries compared in parallel) and moves the record on into a
// two-entry result queue whenever that queue has room. full rises only when both queues
// are backed up behind a stalled pop. The port table starts with every entry free after
// reset; no clearing pass is needed.

module packet_header_receiver #(
	parameter int NUM_PORTS = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        empty,
	input  logic        pop,
	output logic        payload_valid,
	output logic [7:0]  payload_byte,
	output logic        header_done,
	output logic [15:0] source_addr,
	output logic        flag_forbidden,
	output logic        seq_error,
	output logic [2:0]  table_event,
	output logic [2:0]  table_port,
	output logic [1:0]  checksum_status,
	output logic        length_bad
);

	phr_pkg::rec_t front_rec;
	phr_pkg::rec_t back_rec;
	phr_pkg::res_t back_res;
	phr_pkg::res_t out_res;
	logic          accept;
	logic          mid_empty;
	logic          rec_take;
	logic          out_full;

	assign accept = push && !full;

	phr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.rec       (front_rec)
	);

	phr_fifo #(
		.WIDTH ($bits(phr_pkg::rec_t)),
		.DEPTH (phr_pkg::QUEUE_DEPTH)
	) u_rec_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept),
		.wr_data (front_rec),
		.rd_en   (rec_take),
		.rd_data (back_rec),
		.full    (full),
		.empty   (mid_empty)
	);

	phr_back #(
		.NUM_PORTS (NUM_PORTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (!mid_empty),
		.rec       (back_rec),
		.rec_take  (rec_take),
		.res_ready (!out_full),
		.res       (back_res)
	);

	phr_fifo #(
		.WIDTH ($bits(phr_pkg::res_t)),
		.DEPTH (phr_pkg::QUEUE_DEPTH)
	) u_res_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (rec_take),
		.wr_data (back_res),
		.rd_en   (pop),
		.rd_data (out_res),
		.full    (out_full),
		.empty   (empty)
	);

	assign payload_valid   = out_res.payload_valid;
	assign payload_byte    = out_res.payload_byte;
	assign header_done     = out_res.header_done;
	assign source_addr     = out_res.source_addr;
	assign flag_forbidden  = out_res.flag_forbidden;
	assign seq_error       = out_res.seq_error;
	assign table_event     = out_res.table_event;
	assign table_port      = out_res.table_port;
	assign checksum_status = out_res.checksum_status;
	assign length_bad      = out_res.length_bad;

endmodule

// File: tb/sv/tb_top.sv
// tb_top: self-checking testbench for packet_header_receiver, one byte per transfer
// a scoreboard class mirrors the header parse, word sum and port table; tasks push the bytes
// depends on phr_pkg and packet_header_receiver
`timescale 1ns / 100ps

module tb_top;

	localparam int NUM_PORTS    = 5;
	localparam int RANDOM_ITEMS = 1800;
	localparam int MAX_SHOWN    = 100;

	class rx_scoreboard;
		// mirrored receiver state
		logic [phr_pkg::COUNT_W-1:0] cnt;
		logic [15:0] len_w;
		logic [15:0] csum_hdr;
		logic [31:0] seq_hdr;
		logic [7:0]  flag_hdr;
		logic [15:0] src_hdr;
		logic [7:0]  hi_byte;
		logic [31:0] run_sum;
		logic        slot_busy [NUM_PORTS];
		logic [15:0] slot_addr [NUM_PORTS];
		logic [31:0] slot_seq  [NUM_PORTS];

		phr_pkg::res_t pending_results [$];
		int n_err, n_checked, n_hdr, n_cs_ok, n_cs_bad, n_len_bad, n_seq_err, n_forbidden;
		int n_evt [6];

		function new();
			cnt = '0;
			len_w = '0;
			csum_hdr = '0;
			seq_hdr = '0;
			flag_hdr = '0;
			src_hdr = '0;
			hi_byte = '0;
			run_sum = '0;
			for (int i = 0; i < NUM_PORTS; i++) begin
				slot_busy[i] = 1'b0;
				slot_addr[i] = '0;
				slot_seq[i] = '0;
			end
			foreach (n_evt[i]) n_evt[i] = 0;
		endfunction

		function int find_slot(logic [15:0] addr);
			for (int i = 0; i < NUM_PORTS; i++)
				if (slot_busy[i] && slot_addr[i] == addr)
					return i;
			return -1;
		endfunction

		// sequence number that a packet from addr must carry to pass the check
		function bit next_seq_for(input logic [15:0] addr, output logic [31:0] seq);
			int m;
			m = find_slot(addr);
			seq = (m >= 0) ? slot_seq[m] + 32'd1 : 32'd0;
			return m >= 0;
		endfunction

		function int outstanding();
			return pending_results.size();
		endfunction

		// one byte accepted: work out its result
		function void note_byte(logic [7:0] d, logic last);
			logic [phr_pkg::COUNT_W-1:0] idx;
			logic [31:0] s;
			phr_pkg::res_t r;
			int m;
			idx = cnt;
			r = '0;
			case (idx)
				phr_pkg::POS_LEN_HI: begin
					run_sum = '0;
					len_w = {d, 8'h00};
				end
				phr_pkg::POS_LEN_LO: len_w = len_w | {8'h00, d};
				phr_pkg::POS_CSUM_HI: csum_hdr = {d, 8'h00};
				phr_pkg::POS_CSUM_LO: csum_hdr = csum_hdr | {8'h00, d};
				phr_pkg::POS_SEQ_0: seq_hdr = {16'h0000, d, 8'h00};
				phr_pkg::POS_SEQ_1,
				phr_pkg::POS_SEQ_2: seq_hdr = (seq_hdr | {24'h0, d}) << 8;
				phr_pkg::POS_SEQ_3: seq_hdr = seq_hdr | {24'h0, d};
				phr_pkg::POS_FLAG: begin
					flag_hdr = d;
					r.flag_forbidden = ((d & phr_pkg::FLAG_MASK) == phr_pkg::FLAG_MASK);
				end
				phr_pkg::POS_SRC_HI: src_hdr = {d, 8'h00};
				phr_pkg::POS_SRC_LO: src_hdr = src_hdr | {8'h00, d};
				phr_pkg::POS_HDR_END: begin
					r.header_done = 1'b1;
					r.source_addr = src_hdr;
					m = find_slot(src_hdr);
					if (m >= 0) begin
						if (seq_hdr != slot_seq[m] + 32'd1)
							r.seq_error = 1'b1;
						else
							slot_seq[m] = slot_seq[m] + 32'd1;
					end
					if ((flag_hdr & phr_pkg::FLAG_MASK) == phr_pkg::FLAG_SYNC) begin
						if (find_slot(src_hdr) >= 0) begin
							r.table_event = phr_pkg::EV_DUP_SYNC;
						end else begin
							r.table_event = phr_pkg::EV_TABLE_FULL;
							for (int i = 0; i < NUM_PORTS; i++) begin
								if (!slot_busy[i] &&
										r.table_event == phr_pkg::EV_TABLE_FULL) begin
									slot_busy[i] = 1'b1;
									slot_addr[i] = src_hdr;
									slot_seq[i] = seq_hdr;
									r.table_event = phr_pkg::EV_STORED;
									r.table_port = i[2:0];
								end
							end
						end
					end else if ((flag_hdr & phr_pkg::FLAG_MASK) == phr_pkg::FLAG_CLOSE) begin
						m = find_slot(src_hdr);
						if (m >= 0) begin
							slot_busy[m] = 1'b0;
							r.table_event = phr_pkg::EV_CLOSED;
							r.table_port = m[2:0];
						end else begin
							r.table_event = phr_pkg::EV_CLOSE_MISS;
						end
					end
				end
				default: ;
			endcase

			if (idx > phr_pkg::POS_HDR_END) begin
				r.payload_valid = 1'b1;
				r.payload_byte = d;
			end

			// word sum leaves out the checksum word
			if (!idx[0]) begin
				if (idx != phr_pkg::POS_CSUM_HI)
					hi_byte = d;
			end else if (idx != phr_pkg::POS_CSUM_LO) begin
				run_sum = run_sum + {16'h0000, hi_byte, d};
				hi_byte = '0;
			end
			if (len_w >= 16'd4 && {13'h0, idx} == {14'h0, len_w, 2'b00} - 32'd1) begin
				s = run_sum;
				if (s > 32'h0000ffff)
					s = {16'h0000, s[15:0]} + {16'h0000, s[31:16]};
				s = {16'h0000, ~s[15:0]};
				run_sum = s;
				r.checksum_status = (csum_hdr == s[15:0]) ? phr_pkg::CS_MATCH :
					phr_pkg::CS_MISMATCH;
			end

			if (last) begin
				r.length_bad = ({13'h0, idx} + 32'd1) != {14'h0, len_w, 2'b00};
				cnt = '0;
			end else begin
				cnt = idx + 1'b1;
			end

			n_hdr += r.header_done;
			n_cs_ok += (r.checksum_status == phr_pkg::CS_MATCH);
			n_cs_bad += (r.checksum_status == phr_pkg::CS_MISMATCH);
			n_len_bad += r.length_bad;
			n_seq_err += r.seq_error;
			n_forbidden += r.flag_forbidden;
			n_evt[int'(r.table_event)]++;
			pending_results.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				n_err++;
				if (n_err <= MAX_SHOWN)
					$display("%0t: result %0d %s mismatch, expected %0h, got %0h",
						$time, n_checked, name, want, got);
				if (n_err == MAX_SHOWN)
					$display("%0t: further mismatches not shown", $time);
			end
		endfunction

		function void check_result(phr_pkg::res_t got);
			phr_pkg::res_t want;
			if (pending_results.size() == 0) begin
				n_err++;
				if (n_err <= MAX_SHOWN)
					$display("%0t: result with no byte waiting, expected none, got %h",
						$time, got);
				return;
			end
			want = pending_results.pop_front();
			compare_field("payload_valid", want.payload_valid, got.payload_valid);
			compare_field("payload_byte", want.payload_byte, got.payload_byte);
			compare_field("header_done", want.header_done, got.header_done);
			compare_field("source_addr", want.source_addr, got.source_addr);
			compare_field("flag_forbidden", want.flag_forbidden, got.flag_forbidden);
			compare_field("seq_error", want.seq_error, got.seq_error);
			compare_field("table_event", want.table_event, got.table_event);
			compare_field("table_port", want.table_port, got.table_port);
			compare_field("checksum_status", want.checksum_status, got.checksum_status);
			compare_field("length_bad", want.length_bad, got.length_bad);
			n_checked++;
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  data_byte = '0;
	logic        last_byte = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic        payload_valid;
	logic [7:0]  payload_byte;
	logic        header_done;
	logic [15:0] source_addr;
	logic        flag_forbidden;
	logic        seq_error;
	logic [2:0]  table_event;
	logic [2:0]  table_port;
	logic [1:0]  checksum_status;
	logic        length_bad;

	rx_scoreboard sb;
	logic [7:0] pkt_bytes [$];
	bit send_idle = 1'b1;
	bit recv_idle = 1'b1;
	int n_bytes = 0;
	int n_packets = 0;

	packet_header_receiver #(.NUM_PORTS(NUM_PORTS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.empty(empty),
		.pop(pop),
		.payload_valid(payload_valid),
		.payload_byte(payload_byte),
		.header_done(header_done),
		.source_addr(source_addr),
		.flag_forbidden(flag_forbidden),
		.seq_error(seq_error),
		.table_event(table_event),
		.table_port(table_port),
		.checksum_status(checksum_status),
		.length_bad(length_bad)
	);

	always #5 clk = ~clk;

	task automatic send_byte(input logic [7:0] d, input logic l);
		int gap;
		gap = send_idle ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		data_byte <= d;
		last_byte <= l;
		do @(posedge clk); while (full);
		sb.note_byte(d, l);
		n_bytes++;
	endtask

	task automatic send_packet();
		for (int i = 0; i < pkt_bytes.size(); i++)
			send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
		n_packets++;
	endtask

	// folded and inverted word sum over the first n bytes of pkt_bytes, skipping the checksum word
	function automatic logic [15:0] packet_checksum(int n);
		logic [31:0] s;
		s = '0;
		for (int i = 0; i + 1 < n; i += 2)
			if (i != 2)
				s = s + {16'h0000, pkt_bytes[i], pkt_bytes[i+1]};
		if (s > 32'h0000ffff)
			s = {16'h0000, s[15:0]} + {16'h0000, s[31:16]};
		return ~s[15:0];
	endfunction

	task automatic make_packet(input logic [15:0] len, input logic [31:0] seq,
			input logic [7:0] flag, input logic [15:0] src, input int pay_n,
			input bit good_csum);
		logic [15:0] c;
		pkt_bytes.delete();
		pkt_bytes.push_back(len[15:8]);
		pkt_bytes.push_back(len[7:0]);
		pkt_bytes.push_back(8'($urandom));
		pkt_bytes.push_back(8'($urandom));
		for (int i = 3; i >= 0; i--)
			pkt_bytes.push_back(seq[8*i +: 8]);
		pkt_bytes.push_back(flag);
		repeat (3) pkt_bytes.push_back(8'($urandom));
		pkt_bytes.push_back(src[15:8]);
		pkt_bytes.push_back(src[7:0]);
		repeat (2 + pay_n) pkt_bytes.push_back(8'($urandom));
		if (good_csum && 4 * int'(len) <= pkt_bytes.size()) begin
			c = packet_checksum(4 * int'(len));
			pkt_bytes[2] = c[15:8];
			pkt_bytes[3] = c[7:0];
		end
	endtask

	// a few addresses recur so that the table fills, matches and frees
	function automatic logic [15:0] pick_source();
		if ($urandom_range(0, 6) == 0)
			return 16'($urandom);
		case ($urandom_range(0, 6))
			0: return 16'h0000;
			1: return 16'hffff;
			2: return 16'h1234;
			3: return 16'h00a5;
			4: return 16'h8001;
			5: return 16'h5a5a;
			default: return 16'h7ffe;
		endcase
	endfunction

	function automatic logic [7:0] pick_flag();
		logic [7:0] mid;
		int r;
		mid = 8'($urandom) & 8'h7e;
		r = $urandom_range(0, 19);
		if (r < 8)
			return phr_pkg::FLAG_SYNC | mid;
		else if (r < 13)
			return phr_pkg::FLAG_CLOSE | mid;
		else if (r < 17)
			return mid;
		return phr_pkg::FLAG_MASK | mid;
	endfunction

	task automatic random_packet();
		int kind, pay_n, n;
		logic [15:0] src;
		logic [31:0] seq, nxt;
		kind = $urandom_range(0, 99);
		if (kind >= 85) begin
			// noise: short runs of random bytes
			pkt_bytes.delete();
			n = $urandom_range(1, 40);
			repeat (n) pkt_bytes.push_back(8'($urandom));
		end else begin
			src = pick_source();
			if (sb.next_seq_for(src, nxt) && $urandom_range(0, 4) != 0) begin
				seq = nxt;
			end else begin
				case ($urandom_range(0, 9))
					0: seq = 32'hffff_ffff;
					1: seq = 32'h0000_0000;
					default: seq = $urandom;
				endcase
			end
			pay_n = 4 * $urandom_range(0, 8);
			make_packet(16'((16 + pay_n) / 4), seq, pick_flag(), src, pay_n,
				$urandom_range(0, 6) != 0);
			if (kind >= 70) begin
				case ($urandom_range(0, 2))
					0: begin
						n = $urandom_range(1, pkt_bytes.size());
						while (pkt_bytes.size() > n) void'(pkt_bytes.pop_back());
					end
					1: begin
						pkt_bytes[0] = ($urandom_range(0, 7) == 0) ? 8'hff : 8'h00;
						pkt_bytes[1] = 8'($urandom_range(0, 15));
					end
					default: repeat ($urandom_range(1, 7)) pkt_bytes.push_back(8'($urandom));
				endcase
			end
		end
		send_packet();
	endtask

	// result side: random stalls, one check per transfer
	initial begin
		int stall;
		phr_pkg::res_t got;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = recv_idle ? $urandom_range(0, 15) : 0;
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			got.payload_valid = payload_valid;
			got.payload_byte = payload_byte;
			got.header_done = header_done;
			got.source_addr = source_addr;
			got.flag_forbidden = flag_forbidden;
			got.seq_error = seq_error;
			got.table_event = phr_pkg::table_event_t'(table_event);
			got.table_port = table_port;
			got.checksum_status = phr_pkg::csum_status_t'(checksum_status);
			got.length_bad = length_bad;
			sb.check_result(got);
		end
	end

	initial begin
		int start_bytes;
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// short broken packet with an extreme length, then a sync from the top address
		pkt_bytes = '{8'hff, 8'h00, 8'h00, 8'hff};
		send_packet();
		make_packet(16'd5, 32'hffff_ffff, phr_pkg::FLAG_SYNC, 16'hffff, 4, 1'b1);
		send_packet();

		start_bytes = n_bytes;
		while (n_bytes - start_bytes < RANDOM_ITEMS) begin
			send_idle = $urandom_range(0, 2) != 0;
			recv_idle = $urandom_range(0, 2) != 0;
			random_packet();
		end
		push <= 1'b0;

		while (sb.outstanding() > 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("checked %0d results over %0d packets: %0d headers, ",
			sb.n_checked, n_packets, sb.n_hdr,
			"checksum ok %0d / bad %0d, length errors %0d",
			sb.n_cs_ok, sb.n_cs_bad, sb.n_len_bad);
		$display("port table: stored %0d, dup sync %0d, full %0d, closed %0d, ",
			sb.n_evt[phr_pkg::EV_STORED], sb.n_evt[phr_pkg::EV_DUP_SYNC],
			sb.n_evt[phr_pkg::EV_TABLE_FULL], sb.n_evt[phr_pkg::EV_CLOSED],
			"close miss %0d; seq errors %0d, forbidden flags %0d",
			sb.n_evt[phr_pkg::EV_CLOSE_MISS], sb.n_seq_err, sb.n_forbidden);
		if (sb.n_err == 0 && sb.outstanding() == 0)
			$display("** packet_header_receiver: PASSED **");
		else
			$display("** packet_header_receiver: FAILED **");
		$finish;
	end

	initial begin
		#(5_000_000);
		$display("%0t: run did not finish in time, %0d results still waiting",
			$time, sb.outstanding());
		$display("** packet_header_receiver: FAILED **");
		$finish;
	end

endmodule
